// ===== sv/pms_pkg.sv =====
// Shared types and constants for the packed multi-stack store.
package pms_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned SID_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NUMST_W  = 4;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned CFG_A_W  = 1;
  localparam int unsigned CFG_D_W  = 7;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_NUM_STACKS = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_CAPACITY   = 1'b1;

  // Configuration reset values
  localparam logic [NUMST_W-1:0] NUM_STACKS_RST = 4'd1;
  localparam logic [CAP_W-1:0]   CAPACITY_RST   = 7'd64;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_SHOW = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_ID   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_PUSH_SH,
    S_POP_RD,
    S_POP_CAP,
    S_POP_SH,
    S_DREAD,
    S_DCAP,
    S_RESP
  } state_t;

endpackage

// ===== sv/pms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/packed_multi_stack_store.sv =====
// Packed multi-stack store: up to MAX_STACKS LIFO stacks packed back to back in one RAM of
// STORE_DEPTH 32-bit words. Each request is handled alone. Every push, pop or display on a
// valid stack first scans the count table, one stack per cycle, then passes a decision state.
// A push then moves every element above its insertion point up one word, one RAM word per
// cycle, and writes the new value. A pop reads the top word, then moves the words above it
// down, one per cycle. A display reads each element and then hands it to the output register,
// because the RAM read data is registered; it reads the next element only after the last one
// is handed over. An overflow, an underflow or an empty display goes from the decision state
// straight to the result. A bad stack id skips the scan, and an unused request kind gives no
// result. A stalled result holds the sequencer until the result register frees. The single
// RAM port pair sets the moving rate. The RAM contents are undefined after reset, and only
// words below the total count are read.
module packed_multi_stack_store #(
  parameter int unsigned MAX_STACKS  = 8,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // push_value[31:0]
  input  logic [4:0]                   in_tuser,   // req_type[1:0], stack_id[4:2]
  // Result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // data[31:0]
  output logic [1:0]                   out_tuser,  // status[1:0]
  output logic                         out_tlast,
  // Configuration writes
  input  logic                         cfg_we,
  input  logic [pms_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [pms_pkg::CFG_D_W-1:0]  cfg_wdata
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned DW = pms_pkg::DATA_W;

  // Configuration registers
  logic [pms_pkg::NUMST_W-1:0] num_stacks_r;
  logic [pms_pkg::CAP_W-1:0]   capacity_r;

  // Sequencer state
  pms_pkg::state_t state_r, state_nxt;
  pms_pkg::req_t   req_r, req_nxt;
  logic [pms_pkg::SID_W-1:0] sid_r, sid_nxt;
  logic [DW-1:0]   val_r, val_nxt;
  logic [SW-1:0]   scan_i_r, scan_i_nxt;
  logic [CW-1:0]   base_r, base_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  pms_pkg::status_t resp_status_r, resp_status_nxt;
  logic [DW-1:0]   resp_data_r, resp_data_nxt;

  // Output register
  logic            out_valid_r;
  pms_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]   out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  logic            load_out;
  logic            slot_free;

  // Stack count table
  logic [CW-1:0]   counts_r [MAX_STACKS];
  logic            cnt_we;
  logic [CW-1:0]   cnt_wval;
  logic [SW-1:0]   sid_idx;
  logic [CW-1:0]   cur_cnt;
  logic [CW-1:0]   scan_cnt;

  // RAM port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  logic            in_accept;
  logic            sid_ok;
  logic            full;
  logic [CW-1:0]   ptr_plus;
  logic [CW-1:0]   ptr_minus;
  pms_pkg::req_t   in_req;
  logic [pms_pkg::SID_W-1:0] in_sid;

  assign in_tready = (state_r == pms_pkg::S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_req    = pms_pkg::req_t'(in_tuser[1:0]);
  assign in_sid    = in_tuser[4:2];
  assign sid_ok    = (int'(in_sid) < int'(num_stacks_r)) && (int'(in_sid) < MAX_STACKS);
  assign sid_idx   = SW'(sid_r);
  assign cur_cnt   = counts_r[sid_idx];
  assign scan_cnt  = counts_r[scan_i_r];
  assign full      = (int'(total_r) >= int'(capacity_r)) || (int'(total_r) >= STORE_DEPTH);
  assign ptr_plus  = CW'(ptr_r + 1'b1);
  assign ptr_minus = CW'(ptr_r - 1'b1);
  assign slot_free = !out_valid_r || out_tready;

  // Element store
  pms_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stacks_r <= pms_pkg::NUM_STACKS_RST;
      capacity_r   <= pms_pkg::CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pms_pkg::CFG_NUM_STACKS: num_stacks_r <= cfg_wdata[pms_pkg::NUMST_W-1:0];
        pms_pkg::CFG_CAPACITY:   capacity_r   <= cfg_wdata[pms_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Count table: clear at reset, update at most one entry per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cnt_we) begin
      counts_r[sid_idx] <= cnt_wval;
    end
  end

  // Sequencer and output control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::S_IDLE;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    sid_r         <= sid_nxt;
    val_r         <= val_nxt;
    scan_i_r      <= scan_i_nxt;
    base_r        <= base_nxt;
    total_r       <= total_nxt;
    ptr_r         <= ptr_nxt;
    pos_r         <= pos_nxt;
    wr_addr_r     <= wr_addr_nxt;
    resp_status_r <= resp_status_nxt;
    resp_data_r   <= resp_data_nxt;
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Next state, RAM accesses and result loading
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    sid_nxt         = sid_r;
    val_nxt         = val_r;
    scan_i_nxt      = scan_i_r;
    base_nxt        = base_r;
    total_nxt       = total_r;
    ptr_nxt         = ptr_r;
    pos_nxt         = pos_r;
    wr_pend_nxt     = wr_pend_r;
    wr_addr_nxt     = wr_addr_r;
    resp_status_nxt = resp_status_r;
    resp_data_nxt   = resp_data_r;
    load_out        = 1'b0;
    out_status_nxt  = resp_status_r;
    out_data_nxt    = resp_data_r;
    out_last_nxt    = 1'b1;
    cnt_we          = 1'b0;
    cnt_wval        = cur_cnt;
    ram_re          = 1'b0;
    ram_raddr       = ptr_r[AW-1:0];
    // Pending shift write uses the word read in the previous cycle
    ram_we          = wr_pend_r;
    ram_waddr       = wr_addr_r;
    ram_wdata       = ram_rdata;

    unique case (state_r)
      pms_pkg::S_IDLE: begin
        if (in_accept) begin
          req_nxt = in_req;
          sid_nxt = in_sid;
          val_nxt = in_tdata;
          if (in_req == pms_pkg::REQ_NONE) begin
            state_nxt = pms_pkg::S_IDLE;
          end else if (!sid_ok) begin
            resp_status_nxt = pms_pkg::ST_BAD_ID;
            resp_data_nxt   = '0;
            state_nxt       = pms_pkg::S_RESP;
          end else begin
            scan_i_nxt = '0;
            base_nxt   = '0;
            total_nxt  = '0;
            state_nxt  = pms_pkg::S_SCAN;
          end
        end
      end

      // Accumulate the total count and the base of the addressed stack
      pms_pkg::S_SCAN: begin
        total_nxt = CW'(total_r + scan_cnt);
        if (int'(scan_i_r) < int'(sid_r)) begin
          base_nxt = CW'(base_r + scan_cnt);
        end
        if (scan_i_r == SW'(MAX_STACKS - 1)) begin
          state_nxt = pms_pkg::S_DECIDE;
        end else begin
          scan_i_nxt = SW'(scan_i_r + 1'b1);
        end
      end

      pms_pkg::S_DECIDE: begin
        wr_pend_nxt = 1'b0;
        unique case (req_r)
          pms_pkg::REQ_PUSH: begin
            if (full) begin
              resp_status_nxt = pms_pkg::ST_OVERFLOW;
              resp_data_nxt   = '0;
              state_nxt       = pms_pkg::S_RESP;
            end else begin
              pos_nxt   = CW'(base_r + cur_cnt);
              ptr_nxt   = total_r;
              state_nxt = pms_pkg::S_PUSH_SH;
            end
          end
          pms_pkg::REQ_POP: begin
            if (cur_cnt == '0) begin
              resp_status_nxt = pms_pkg::ST_EMPTY;
              resp_data_nxt   = '1;
              state_nxt       = pms_pkg::S_RESP;
            end else begin
              pos_nxt   = CW'(base_r + cur_cnt - 1'b1);
              state_nxt = pms_pkg::S_POP_RD;
            end
          end
          pms_pkg::REQ_SHOW: begin
            if (cur_cnt == '0) begin
              resp_status_nxt = pms_pkg::ST_EMPTY;
              resp_data_nxt   = '0;
              state_nxt       = pms_pkg::S_RESP;
            end else begin
              ptr_nxt   = base_r;
              pos_nxt   = CW'(base_r + cur_cnt);
              state_nxt = pms_pkg::S_DREAD;
            end
          end
          default: state_nxt = pms_pkg::S_IDLE;
        endcase
      end

      // Move higher words up one place, top down, then insert the value
      pms_pkg::S_PUSH_SH: begin
        if (ptr_r > pos_r) begin
          ram_re      = 1'b1;
          ram_raddr   = ptr_minus[AW-1:0];
          wr_addr_nxt = ptr_r[AW-1:0];
          wr_pend_nxt = 1'b1;
          ptr_nxt     = ptr_minus;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            ram_we          = 1'b1;
            ram_waddr       = pos_r[AW-1:0];
            ram_wdata       = val_r;
            cnt_we          = 1'b1;
            cnt_wval        = CW'(cur_cnt + 1'b1);
            resp_status_nxt = pms_pkg::ST_OK;
            resp_data_nxt   = '0;
            state_nxt       = pms_pkg::S_RESP;
          end
        end
      end

      // Read the top word of the stack
      pms_pkg::S_POP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r[AW-1:0];
        ptr_nxt   = CW'(pos_r + 1'b1);
        state_nxt = pms_pkg::S_POP_CAP;
      end

      pms_pkg::S_POP_CAP: begin
        val_nxt   = ram_rdata;
        state_nxt = pms_pkg::S_POP_SH;
      end

      // Move higher words down one place, bottom up
      pms_pkg::S_POP_SH: begin
        if (ptr_r < total_r) begin
          ram_re      = 1'b1;
          ram_raddr   = ptr_r[AW-1:0];
          wr_addr_nxt = ptr_minus[AW-1:0];
          wr_pend_nxt = 1'b1;
          ptr_nxt     = ptr_plus;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            cnt_we          = 1'b1;
            cnt_wval        = CW'(cur_cnt - 1'b1);
            resp_status_nxt = pms_pkg::ST_OK;
            resp_data_nxt   = val_r;
            state_nxt       = pms_pkg::S_RESP;
          end
        end
      end

      pms_pkg::S_DREAD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r[AW-1:0];
        state_nxt = pms_pkg::S_DCAP;
      end

      // Hand one displayed element to the output register
      pms_pkg::S_DCAP: begin
        if (slot_free) begin
          load_out       = 1'b1;
          out_status_nxt = pms_pkg::ST_OK;
          out_data_nxt   = ram_rdata;
          out_last_nxt   = (ptr_plus == pos_r);
          ptr_nxt        = ptr_plus;
          state_nxt      = (ptr_plus == pos_r) ? pms_pkg::S_IDLE : pms_pkg::S_DREAD;
        end
      end

      pms_pkg::S_RESP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = pms_pkg::S_IDLE;
        end
      end

      default: state_nxt = pms_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // A RAM write always lands inside the store
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (int'(ram_waddr) < STORE_DEPTH))
    else $error("store write address out of range");

  // A shift never reads the word it writes in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write collide during shift");

  // The final result of a request returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_last_nxt) |=> (state_r == pms_pkg::S_IDLE))
    else $error("sequencer busy after final result");

  // Display reads stay below the end of the addressed stack
  a_disp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pms_pkg::S_DCAP) |-> (ptr_r < pos_r))
    else $error("display pointer past stack end");

endmodule

// ===== test/pms_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the packed multi-stack store: mirrors the stacks and compares every result.
module pms_checker #(
  parameter int unsigned MAX_STACKS  = 8,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // push_value[31:0]
  input  logic [4:0]                  in_tuser,   // req_type[1:0], stack_id[4:2]
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [31:0]                 out_tdata,  // data[31:0]
  input  logic [1:0]                  out_tuser,  // status[1:0]
  input  logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [pms_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [pms_pkg::CFG_D_W-1:0] cfg_wdata,
  output int unsigned                 owed_results,
  output int unsigned                 fail_count
);

  typedef struct packed {
    pms_pkg::status_t status;
    logic [31:0]      data;
    logic             last;
  } stack_result_t;

  // Mirror of the shared store, the per-stack fill levels and the registers
  logic [31:0]                 mirror_words [STORE_DEPTH];
  int unsigned                 stack_fill [MAX_STACKS];
  logic [pms_pkg::NUMST_W-1:0] stacks_reg;
  logic [pms_pkg::CAP_W-1:0]   capacity_reg;
  stack_result_t               expected_results [$];
  int unsigned                 mismatches = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic add_expected(pms_pkg::status_t status, logic [31:0] data, logic last);
    stack_result_t entry;
    entry.status = status;
    entry.data   = data;
    entry.last   = last;
    expected_results.push_back(entry);
  endtask

  // Apply one request to the mirror and queue the results it produces
  task automatic apply_request(pms_pkg::req_t kind, int unsigned sid, logic [31:0] value);
    int unsigned live_stacks, room, total, base, fill, pos, i;
    logic [31:0] word;
    live_stacks = (stacks_reg < MAX_STACKS) ? stacks_reg : MAX_STACKS;
    room        = (capacity_reg < STORE_DEPTH) ? capacity_reg : STORE_DEPTH;
    total       = 0;
    base        = 0;
    if (kind == pms_pkg::REQ_NONE)
      return;
    if (sid >= live_stacks) begin
      add_expected(pms_pkg::ST_BAD_ID, 32'h0, 1'b1);
      return;
    end
    for (i = 0; i < MAX_STACKS; i++) begin
      total += stack_fill[i];
      if (i < sid)
        base += stack_fill[i];
    end
    fill = stack_fill[sid];
    case (kind)
      pms_pkg::REQ_PUSH: begin
        if (total >= room || total >= STORE_DEPTH) begin
          add_expected(pms_pkg::ST_OVERFLOW, 32'h0, 1'b1);
        end else begin
          // open a slot at the top of this stack, moving higher stacks up
          pos = base + fill;
          for (i = total; i > pos; i--)
            mirror_words[i] = mirror_words[i-1];
          mirror_words[pos] = value;
          stack_fill[sid]   = fill + 1;
          add_expected(pms_pkg::ST_OK, 32'h0, 1'b1);
        end
      end
      pms_pkg::REQ_POP: begin
        if (fill == 0) begin
          add_expected(pms_pkg::ST_EMPTY, 32'hFFFF_FFFF, 1'b1);
        end else begin
          // take the top word, then close the gap from above
          pos  = base + fill - 1;
          word = mirror_words[pos];
          for (i = pos; i + 1 < total; i++)
            mirror_words[i] = mirror_words[i+1];
          stack_fill[sid] = fill - 1;
          add_expected(pms_pkg::ST_OK, word, 1'b1);
        end
      end
      default: begin
        if (fill == 0) begin
          add_expected(pms_pkg::ST_EMPTY, 32'h0, 1'b1);
        end else begin
          for (i = 0; i < fill; i++)
            add_expected(pms_pkg::ST_OK, mirror_words[base+i], (i + 1 == fill));
        end
      end
    endcase
  endtask

  task automatic check_result();
    stack_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing owed", out_tdata, 32'h0);
      return;
    end
    want = expected_results.pop_front();
    if (out_tuser !== want.status)
      report_mismatch("status", {30'h0, out_tuser}, {30'h0, want.status});
    if (out_tdata !== want.data)
      report_mismatch("data", out_tdata, want.data);
    if (out_tlast !== want.last)
      report_mismatch("last", {31'h0, out_tlast}, {31'h0, want.last});
  endtask

  // Track register writes, request transfers and result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (stack_fill[j])
        stack_fill[j] = 0;
      stacks_reg   = pms_pkg::NUM_STACKS_RST;
      capacity_reg = pms_pkg::CAPACITY_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pms_pkg::CFG_NUM_STACKS: stacks_reg   = cfg_wdata[pms_pkg::NUMST_W-1:0];
          default:                 capacity_reg = cfg_wdata[pms_pkg::CAP_W-1:0];
        endcase
      end
      if (in_tvalid && in_tready)
        apply_request(pms_pkg::req_t'(in_tuser[1:0]), in_tuser[4:2], in_tdata);
      if (out_tvalid && out_tready)
        check_result();
    end
    owed_results <= expected_results.size();
    fail_count   <= mismatches;
  end

endmodule

// ===== test/packed_multi_stack_store_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the packed multi-stack store: clock, reset, request stimulus and verdict.
module packed_multi_stack_store_tb;

  localparam int unsigned STACKS_P      = 8;
  localparam int unsigned DEPTH_P       = 64;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 300;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [31:0]                 in_tdata   = 32'h0;
  logic [4:0]                  in_tuser   = 5'h0;   // req_type[1:0], stack_id[4:2]
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [31:0]                 out_tdata;           // data[31:0]
  logic [1:0]                  out_tuser;           // status[1:0]
  logic                        out_tlast;
  logic                        cfg_we     = 1'b0;
  logic [pms_pkg::CFG_A_W-1:0] cfg_addr   = pms_pkg::CFG_NUM_STACKS;
  logic [pms_pkg::CFG_D_W-1:0] cfg_wdata  = '0;

  int unsigned owed_results;
  int unsigned fail_count;

  // Stimulus controls seen by the receiver process and the request tasks
  logic quiet   = 1'b0;
  logic hold_go = 1'b0;
  int   live_stacks = 1;

  logic [31:0] extreme_words [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};

  always #1 clk = ~clk;

  packed_multi_stack_store #(
    .MAX_STACKS  (STACKS_P),
    .STORE_DEPTH (DEPTH_P)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pms_checker #(
    .MAX_STACKS  (STACKS_P),
    .STORE_DEPTH (DEPTH_P)
  ) result_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .owed_results (owed_results),
    .fail_count   (fail_count)
  );

  // Result side: random stall bursts, one long hold-off, none once quiet
  int rx_gap  = 0;
  int rx_hold = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        rx_hold    = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request, with an optional idle burst ahead of it, and hold until transfer
  task automatic send_req(pms_pkg::req_t kind, logic [2:0] sid, logic [31:0] value);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sid, kind};
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every owed result has come, then let the block settle
  task automatic drain_and_settle(int unsigned settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (owed_results != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_config(logic [pms_pkg::CFG_D_W-1:0] stacks,
                            logic [pms_pkg::CFG_D_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_addr  <= pms_pkg::CFG_NUM_STACKS;
    cfg_wdata <= stacks;
    @(posedge clk);
    cfg_addr  <= pms_pkg::CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_stacks = (stacks[pms_pkg::NUMST_W-1:0] < STACKS_P) ?
                  stacks[pms_pkg::NUMST_W-1:0] : STACKS_P;
  endtask

  // Mostly well-formed traffic on live stacks, with some bad ids and unused kinds
  task automatic run_random(int unsigned count);
    pms_pkg::req_t kind;
    logic [2:0]    sid;
    logic [31:0]   value;
    int unsigned   pick;
    repeat (count) begin
      pick  = $urandom_range(0, 99);
      sid   = (live_stacks > 0) ? 3'($urandom_range(0, live_stacks - 1))
                                : 3'($urandom_range(0, 7));
      value = ($urandom_range(0, 3) == 0) ? extreme_words[$urandom_range(0, 3)] : $urandom;
      if (pick < 45) begin
        kind = pms_pkg::REQ_PUSH;
      end else if (pick < 75) begin
        kind = pms_pkg::REQ_POP;
      end else if (pick < 90) begin
        kind = pms_pkg::REQ_SHOW;
      end else if (pick < 96) begin
        kind = pms_pkg::req_t'(2'($urandom_range(0, 2)));
        sid  = 3'($urandom_range(0, 7));
      end else begin
        kind = pms_pkg::REQ_NONE;
      end
      send_req(kind, sid, value);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one stack, full capacity
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'h8000_0000);
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'hFFFF_FFFF);
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'h0);
    send_req(pms_pkg::REQ_SHOW, 3'd0, 32'h0);
    repeat (4) send_req(pms_pkg::REQ_POP, 3'd0, 32'h0);
    send_req(pms_pkg::REQ_POP, 3'd0, 32'h0);          // underflow
    send_req(pms_pkg::REQ_SHOW, 3'd0, 32'h0);         // empty stack
    send_req(pms_pkg::REQ_PUSH, 3'd1, 32'h5555_5555); // bad id
    send_req(pms_pkg::REQ_SHOW, 3'd7, 32'h0);         // bad id
    send_req(pms_pkg::REQ_NONE, 3'd0, $urandom);
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'h1234_5678);
    drain_and_settle(SETTLE_CYCLES);

    // Eight stacks with a capacity of three: shifting across stacks up to a full store
    set_config(7'd8, 7'd3);
    send_req(pms_pkg::REQ_PUSH, 3'd7, 32'hA5A5_A5A5);
    send_req(pms_pkg::REQ_PUSH, 3'd3, 32'h0000_0001);
    send_req(pms_pkg::REQ_PUSH, 3'd0, 32'hDEAD_BEEF); // fills the capacity
    send_req(pms_pkg::REQ_SHOW, 3'd7, 32'h0);
    send_req(pms_pkg::REQ_SHOW, 3'd0, 32'h0);
    send_req(pms_pkg::REQ_POP, 3'd0, 32'h0);
    send_req(pms_pkg::REQ_POP, 3'd7, 32'h0);
    send_req(pms_pkg::REQ_POP, 3'd5, 32'h0);          // underflow
    drain_and_settle(SETTLE_CYCLES);

    // Small capacity, pause the sender halfway until everything has come back
    set_config(7'd8, 7'd16);
    run_random(35);
    drain_and_settle(0);
    run_random(35);
    drain_and_settle(SETTLE_CYCLES);

    // Capacity above the store size, long receiver hold-off at the start
    set_config(7'd3, 7'd127);
    hold_go <= 1'b1;
    run_random(70);
    drain_and_settle(SETTLE_CYCLES);

    // Stack count above the limit, with high junk bits in the write data
    set_config(7'h7F, 7'd40);
    run_random(60);
    drain_and_settle(SETTLE_CYCLES);

    // No stacks and no capacity: every request is refused
    set_config(7'd0, 7'd0);
    run_random(15);
    drain_and_settle(SETTLE_CYCLES);

    // Capacity lowered below the current total
    set_config(7'd5, 7'd1);
    run_random(30);
    drain_and_settle(SETTLE_CYCLES);

    // Full store, no idling on either side
    set_config(7'd8, 7'd64);
    quiet <= 1'b1;
    run_random(80);
    drain_and_settle(SETTLE_CYCLES);

    if (fail_count == 0 && owed_results == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pms_pkg.sv
sv/pms_ram.sv
sv/packed_multi_stack_store.sv
test/pms_checker.sv
test/packed_multi_stack_store_tb.sv
